// ----- rtl/core/stf_pkg.sv -----
package stf_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic EDGE_SHORT = 1'b0;
  localparam logic EDGE_LONG  = 1'b1;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic edge_sel;
    logic latch_a;
    logic latch_b;
  } stf_cmd_t;

  typedef struct packed {
    logic need_setup;
    logic div_done;
  } stf_stat_t;

endpackage

// ----- rtl/core/scanline_triangle_fill.sv -----
// A result is registered and shown in the cycle after its input transfer.
// Throughput: one pixel per cycle along a row while out_ready is high; a load
// or a row change starts a row setup, in which a single shared bit-serial
// restoring divider computes both edge quotients; no input is taken while it runs.
// Reset: synchronous active-low rst_n; block idle, no result pending.
module scanline_triangle_fill import stf_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [COORD_BITS-1:0] in_first_x,
  input  logic [COORD_BITS-1:0] in_first_y,
  input  logic [COORD_BITS-1:0] in_second_x,
  input  logic [COORD_BITS-1:0] in_second_y,
  input  logic [COORD_BITS-1:0] in_third_x,
  input  logic [COORD_BITS-1:0] in_third_y,
  input  logic [31:0]           in_fill_color,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic [31:0]           out_pixel_color,
  output logic                  out_pixel_valid,
  output logic                  out_last_pixel
);

  stf_cmd_t  cmd;
  stf_stat_t stat;

  stf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  stf_dp #(.CB(COORD_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_command),
    .in_first_x      (in_first_x),
    .in_first_y      (in_first_y),
    .in_second_x     (in_second_x),
    .in_second_y     (in_second_y),
    .in_third_x      (in_third_x),
    .in_third_y      (in_third_y),
    .in_fill_color   (in_fill_color),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_pixel_valid (out_pixel_valid),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

// ----- rtl/core/stf_div.sv -----
module stf_div import stf_pkg::*; #(
  parameter int CB = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*CB-1:0] dividend,
  input  logic [CB:0]     divisor,
  output logic            done,
  output logic [2*CB-1:0] quotient
);

  localparam int CW = $clog2(2*CB + 1);

  logic [2*CB-1:0] q_r, q_nxt;
  logic [CB:0]     rem_r, rem_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            done_r, done_nxt;
  logic [CB+1:0]   shifted;
  logic [CB+2:0]   trial;

  always_comb begin
    shifted  = {rem_r, q_r[2*CB-1]};
    trial    = {1'b0, shifted} - {2'b00, divisor};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(2*CB);
    end else if (cnt_r != '0) begin
      if (!trial[CB+2]) begin
        rem_nxt = trial[CB:0];
        q_nxt   = {q_r[2*CB-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[CB:0];
        q_nxt   = {q_r[2*CB-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- rtl/core/stf_dp.sv -----
module stf_dp import stf_pkg::*; #(
  parameter int CB = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stf_cmd_t      cmd,
  output stf_stat_t     stat,
  input  logic          in_command,
  input  logic [CB-1:0] in_first_x,
  input  logic [CB-1:0] in_first_y,
  input  logic [CB-1:0] in_second_x,
  input  logic [CB-1:0] in_second_y,
  input  logic [CB-1:0] in_third_x,
  input  logic [CB-1:0] in_third_y,
  input  logic [31:0]   in_fill_color,
  output logic [CB-1:0] out_pixel_x,
  output logic [CB-1:0] out_pixel_y,
  output logic [31:0]   out_pixel_color,
  output logic          out_pixel_valid,
  output logic          out_last_pixel
);

  logic [CB-1:0] vx_r [3];
  logic [CB-1:0] vy_r [3];
  logic [CB-1:0] sx [3];
  logic [CB-1:0] sy [3];
  logic [CB-1:0] tx, ty;
  logic [31:0]   color_r;
  logic [CB-1:0] row_r, col_r, end_r, a_r;
  logic          half_r, busy_r;

  logic [CB-1:0] px_r, py_r;
  logic [31:0]   pc_r;
  logic          pv_r, pl_r;

  logic          is_load, col_more, final_px;

  // edge operand selection
  logic [CB-1:0]   xa, xb, ys, ye;
  logic [CB-1:0]   adx, k;
  logic            neg;
  logic [CB:0]     den;
  logic [2*CB-1:0] prod;
  logic            div_done;
  logic [2*CB-1:0] quot;
  logic [CB:0]     qx, ex;
  logic [CB-1:0]   edge_x;

  always_comb begin
    tx = '0;
    ty = '0;
    sx[0] = in_first_x;  sy[0] = in_first_y;
    sx[1] = in_second_x; sy[1] = in_second_y;
    sx[2] = in_third_x;  sy[2] = in_third_y;
    if (sy[0] > sy[1]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
    end
    if (sy[0] > sy[2]) begin
      tx = sx[0]; ty = sy[0]; sx[0] = sx[2]; sy[0] = sy[2]; sx[2] = tx; sy[2] = ty;
    end
    if (sy[1] > sy[2]) begin
      tx = sx[1]; ty = sy[1]; sx[1] = sx[2]; sy[1] = sy[2]; sx[2] = tx; sy[2] = ty;
    end
  end

  always_comb begin
    if (cmd.edge_sel == EDGE_LONG) begin
      xa = vx_r[0]; xb = vx_r[2]; ys = vy_r[0]; ye = vy_r[2];
      den = {1'b0, ye - ys};
    end else if (!half_r) begin
      xa = vx_r[0]; xb = vx_r[1]; ys = vy_r[0]; ye = vy_r[1];
      den = {1'b0, ye - ys} + 1'b1;
    end else begin
      xa = vx_r[1]; xb = vx_r[2]; ys = vy_r[1]; ye = vy_r[2];
      den = {1'b0, ye - ys} + 1'b1;
    end
    neg  = xb < xa;
    adx  = neg ? (xa - xb) : (xb - xa);
    k    = row_r - ys;
    prod = {{CB{1'b0}}, adx} * {{CB{1'b0}}, k};
    qx   = quot[CB:0];
    ex   = neg ? ({1'b0, xa} - qx) : ({1'b0, xa} + qx);
    edge_x = (den == '0) ? xa : ex[CB-1:0];
  end

  stf_div #(.CB(CB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  assign is_load  = (in_command == CMD_LOAD);
  assign col_more = col_r < end_r;
  assign final_px = busy_r && !col_more && half_r && !(row_r < vy_r[2]);

  assign stat.need_setup = is_load || (busy_r && !col_more && !final_px);
  assign stat.div_done   = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      half_r <= 1'b0;
    end else if (cmd.accept) begin
      if (is_load) begin
        busy_r <= 1'b1;
        half_r <= 1'b0;
      end else if (busy_r && !col_more) begin
        if (!half_r && !(row_r < vy_r[1])) half_r <= 1'b1;
        if (final_px) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (is_load) begin
        for (int i = 0; i < 3; i++) begin
          vx_r[i] <= sx[i];
          vy_r[i] <= sy[i];
        end
        color_r <= in_fill_color;
        row_r   <= sy[0];
        px_r <= '0; py_r <= '0; pc_r <= '0; pv_r <= 1'b0; pl_r <= 1'b0;
      end else if (!busy_r) begin
        px_r <= '0; py_r <= '0; pc_r <= '0; pv_r <= 1'b0; pl_r <= 1'b0;
      end else begin
        px_r <= col_r; py_r <= row_r; pc_r <= color_r; pv_r <= 1'b1;
        pl_r <= final_px;
        if (col_more) begin
          col_r <= col_r + 1'b1;
        end else if (!half_r) begin
          row_r <= (row_r < vy_r[1]) ? row_r + 1'b1 : vy_r[1];
        end else if (row_r < vy_r[2]) begin
          row_r <= row_r + 1'b1;
        end
      end
    end
    if (cmd.latch_a) a_r <= edge_x;
    if (cmd.latch_b) begin
      col_r <= (a_r > edge_x) ? edge_x : a_r;
      end_r <= (a_r > edge_x) ? a_r : edge_x;
    end
  end

  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_color = pc_r;
  assign out_pixel_valid = pv_r;
  assign out_last_pixel  = pl_r;

endmodule

// ----- rtl/core/stf_ctrl.sv -----
module stf_ctrl import stf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  stf_stat_t stat,
  output stf_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_A_GO   = 3'd1;
  localparam logic [2:0] ST_A_WAIT = 3'd2;
  localparam logic [2:0] ST_B_GO   = 3'd3;
  localparam logic [2:0] ST_B_WAIT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       acc;

  assign in_ready = (state_r == ST_IDLE) && (!ov_r || out_ready);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd.accept    = acc;
    cmd.div_start = 1'b0;
    cmd.edge_sel  = EDGE_SHORT;
    cmd.latch_a   = 1'b0;
    cmd.latch_b   = 1'b0;
    unique case (state_r)
      ST_IDLE:   if (acc && stat.need_setup) state_nxt = ST_A_GO;
      ST_A_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_A_WAIT;
      end
      ST_A_WAIT: if (stat.div_done) begin
        cmd.latch_a = 1'b1;
        state_nxt   = ST_B_GO;
      end
      ST_B_GO: begin
        cmd.div_start = 1'b1;
        cmd.edge_sel  = EDGE_LONG;
        state_nxt     = ST_B_WAIT;
      end
      ST_B_WAIT: begin
        cmd.edge_sel = EDGE_LONG;
        if (stat.div_done) begin
          cmd.latch_b = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
    ov_nxt = acc ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("input taken during setup");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r) else $error("result dropped");
  a_b_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch_b |=> (state_r == ST_IDLE)) else $error("setup did not finish");
  a_setup_start: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && stat.need_setup) |=> (state_r == ST_A_GO)) else $error("setup not started");

endmodule
